// ===== rtl/core/aesp_pkg.sv =====
// Shared types, character constants and final-byte decode for the escape sequence parser.
package aesp_pkg;

  // Command codes carried in each result
  typedef enum logic [4:0] {
    CMD_NONE        = 5'd0,
    CMD_BELL        = 5'd1,
    CMD_BACKSPACE   = 5'd2,
    CMD_HOME        = 5'd3,
    CMD_UP          = 5'd4,
    CMD_DOWN        = 5'd5,
    CMD_RIGHT       = 5'd6,
    CMD_LEFT        = 5'd7,
    CMD_COLUMN      = 5'd8,
    CMD_ROW         = 5'd9,
    CMD_POSITION    = 5'd10,
    CMD_TAB         = 5'd11,
    CMD_ERASE_DISP  = 5'd12,
    CMD_ERASE_LINE  = 5'd13,
    CMD_INS_LINES   = 5'd14,
    CMD_DEL_LINES   = 5'd15,
    CMD_DEL_CHARS   = 5'd16,
    CMD_SCROLL_UP   = 5'd17,
    CMD_SCROLL_DOWN = 5'd18,
    CMD_SGR         = 5'd19,
    CMD_SHOW_CURSOR = 5'd20,
    CMD_INS_CHAR    = 5'd21
  } cmd_t;

  // Field widths of one transaction
  localparam int unsigned CHAR_W   = 21;
  localparam int unsigned OUT_W    = 16;
  localparam int unsigned COUNT_W  = 3;
  localparam int unsigned NUM_RAW  = 4;

  // Control and escape characters
  localparam logic [7:0] CH_BEL   = 8'h07;
  localparam logic [7:0] CH_BS    = 8'h08;
  localparam logic [7:0] CH_ESC   = 8'h1B;
  localparam logic [7:0] CH_CSI   = 8'h5B;  // '['
  localparam logic [7:0] CH_SEMI  = 8'h3B;  // ';'
  localparam logic [7:0] CH_QMARK = 8'h3F;  // '?'
  localparam logic [7:0] CH_ZERO  = 8'h30;  // '0'
  localparam logic [7:0] CH_NINE  = 8'h39;  // '9'
  localparam logic [7:0] CH_HOME  = 8'h48;  // 'H' directly after ESC

  // One parsed result
  typedef struct packed {
    logic                               handled;
    logic                               unknown_sequence;
    cmd_t                               command;
    logic [COUNT_W-1:0]                 param_count;
    logic [NUM_RAW-1:0][OUT_W-1:0]      raw_param;
    logic [OUT_W-1:0]                   first_or_one;
    logic [OUT_W-1:0]                   second_or_one;
  } result_t;

  // Map a CSI final byte to its command, CMD_NONE when not recognized
  function automatic cmd_t arg_final(input logic [7:0] c);
    cmd_t r;
    unique case (c)
      8'h41:        r = CMD_UP;          // 'A'
      8'h42:        r = CMD_DOWN;        // 'B'
      8'h43:        r = CMD_RIGHT;       // 'C'
      8'h44:        r = CMD_LEFT;        // 'D'
      8'h47:        r = CMD_COLUMN;      // 'G'
      8'h64:        r = CMD_ROW;         // 'd'
      8'h48, 8'h66: r = CMD_POSITION;    // 'H', 'f'
      8'h49:        r = CMD_TAB;         // 'I'
      8'h4A:        r = CMD_ERASE_DISP;  // 'J'
      8'h4B:        r = CMD_ERASE_LINE;  // 'K'
      8'h4C:        r = CMD_INS_LINES;   // 'L'
      8'h4D:        r = CMD_DEL_LINES;   // 'M'
      8'h50:        r = CMD_DEL_CHARS;   // 'P'
      8'h53:        r = CMD_SCROLL_UP;   // 'S'
      8'h54:        r = CMD_SCROLL_DOWN; // 'T'
      8'h6D:        r = CMD_SGR;         // 'm'
      8'h68:        r = CMD_SHOW_CURSOR; // 'h'
      8'h40:        r = CMD_INS_CHAR;    // '@'
      default:      r = CMD_NONE;
    endcase
    return r;
  endfunction

endpackage

// ===== rtl/core/aesp_parser.sv =====
// Parser state machine: parameter store, decimal accumulator and per-character decode.
module aesp_parser import aesp_pkg::*; #(
  parameter int unsigned MAX_PARAMS = 4,
  parameter int unsigned PARAM_BITS = 16
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              step,
  input  logic [CHAR_W-1:0] char_code,
  output result_t           result
);

  localparam int unsigned CNT_W = $clog2(MAX_PARAMS + 1);
  localparam int unsigned RAW_N = (MAX_PARAMS < NUM_RAW) ? MAX_PARAMS : NUM_RAW;
  localparam logic [PARAM_BITS-1:0] PARAM_MAX = {PARAM_BITS{1'b1}};

  typedef enum logic [1:0] {
    ST_IDLE = 2'd0,
    ST_ESC  = 2'd1,
    ST_ARG  = 2'd2
  } state_t;

  state_t                                 state, state_next;
  logic [CNT_W-1:0]                       count, count_next;
  logic [MAX_PARAMS-1:0][PARAM_BITS-1:0]  store, store_next;
  logic [PARAM_BITS-1:0]                  acc, acc_next;

  logic [7:0]                             c;
  logic [3:0]                             digit;
  logic [PARAM_BITS+3:0]                  acc_x10;
  logic [MAX_PARAMS-1:0][PARAM_BITS-1:0]  fin_store;
  logic [CNT_W-1:0]                       fin_count;
  logic                                   room;

  assign c     = char_code[7:0];
  assign digit = 4'(c - CH_ZERO);
  assign room  = count < CNT_W'(MAX_PARAMS);

  // Multiply by ten as two shifts and an add, then add the digit
  assign acc_x10 = ({4'b0, acc} << 3) + ({4'b0, acc} << 1) + (PARAM_BITS+4)'(digit);

  // Store as it stands once the pending argument is appended
  always_comb begin
    fin_store = store;
    fin_count = count;
    if (room) begin
      for (int k = 0; k < MAX_PARAMS; k++) begin
        if (count == CNT_W'(k)) fin_store[k] = acc;
      end
      fin_count = count + CNT_W'(1);
    end
  end

  // Decode one character against the current state
  always_comb begin
    state_next = state;
    count_next = count;
    store_next = store;
    acc_next   = acc;
    result     = '0;
    result.command       = CMD_NONE;
    result.first_or_one  = OUT_W'(1);
    result.second_or_one = OUT_W'(1);

    if (char_code[CHAR_W-1:8] == '0) begin
      result.handled = 1'b1;
      unique case (state)
        ST_IDLE: begin
          if (c == CH_BEL)      result.command = CMD_BELL;
          else if (c == CH_BS)  result.command = CMD_BACKSPACE;
          else if (c == CH_ESC) state_next = ST_ESC;
          else                  result.handled = 1'b0;
        end
        ST_ESC: begin
          if (c == CH_ESC)       state_next = ST_ESC;
          else if (c == CH_HOME) result.command = CMD_HOME;
          else if (c == CH_CSI)  state_next = ST_ARG;
          else                   result.handled = 1'b0;
        end
        ST_ARG: begin
          if (c == CH_ESC) begin
            state_next = ST_ESC;
          end else if (c == CH_SEMI) begin
            store_next = fin_store;
            count_next = fin_count;
            acc_next   = '0;
          end else if (c == CH_QMARK) begin
            // consumed with no effect
          end else if (c >= CH_ZERO && c <= CH_NINE) begin
            acc_next = (acc_x10[PARAM_BITS+3:PARAM_BITS] != 4'd0) ? PARAM_MAX
                                                                  : acc_x10[PARAM_BITS-1:0];
          end else begin
            result.command = arg_final(c);
            result.handled = (result.command != CMD_NONE);
          end
        end
        default: result.handled = 1'b0;
      endcase

      // Abort on an unmatched byte; outside idle it flags an unknown sequence
      if (!result.handled) begin
        result.unknown_sequence = (state != ST_IDLE);
        state_next = ST_IDLE;
        count_next = '0;
        store_next = '0;
        acc_next   = '0;
      end

      // Emit the command with the last argument appended, then start over
      if (result.command != CMD_NONE) begin
        result.param_count = COUNT_W'(fin_count);
        for (int k = 0; k < RAW_N; k++) begin
          result.raw_param[k] = OUT_W'(fin_store[k]);
        end
        if (result.raw_param[0] != '0) result.first_or_one  = result.raw_param[0];
        if (result.raw_param[1] != '0) result.second_or_one = result.raw_param[1];
        state_next = ST_IDLE;
        count_next = '0;
        store_next = '0;
        acc_next   = '0;
      end
    end
  end

  // Hold parser state; advance on each accepted character
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      count <= '0;
      store <= '0;
      acc   <= '0;
    end else if (step) begin
      state <= state_next;
      count <= count_next;
      store <= store_next;
      acc   <= acc_next;
    end
  end

endmodule

// ===== rtl/core/ansi_escape_sequence_parser_unit.sv =====
// ANSI CSI escape sequence parser: one character in, one decoded result out per transaction.
// Each accepted character yields exactly one result in the next cycle, and a new character
// can be accepted in every cycle: the whole decode is one pass of shallow logic from the
// parser state into the output register, and the input stays ready while that register
// is empty or being drained. Codes of 256 and above come back with handled low and leave
// the parser untouched. Throughput is one character per cycle while the output is not stalled.
module ansi_escape_sequence_parser_unit import aesp_pkg::*; #(
  parameter int unsigned MAX_PARAMS = 4,
  parameter int unsigned PARAM_BITS = 16
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         s_tvalid,
  output logic         s_tready,
  input  logic [23:0]  s_tdata,   // [20:0] char_code, [23:21] zero
  output logic         m_tvalid,
  input  logic         m_tready,
  output logic [103:0] m_tdata,   // [4:0] command, [7:5] param_count, [23:8] raw_param0,
                                  // [39:24] raw_param1, [55:40] raw_param2,
                                  // [71:56] raw_param3, [87:72] first_or_one,
                                  // [103:88] second_or_one
  output logic [1:0]   m_tuser    // [0] handled, [1] unknown_sequence
);

  logic    step;
  result_t result;
  result_t out_reg;

  assign s_tready = !m_tvalid || m_tready;
  assign step     = s_tvalid && s_tready;

  aesp_parser #(
    .MAX_PARAMS (MAX_PARAMS),
    .PARAM_BITS (PARAM_BITS)
  ) u_parser (
    .clk       (clk),
    .rst       (rst),
    .step      (step),
    .char_code (s_tdata[CHAR_W-1:0]),
    .result    (result)
  );

  // Output register: load on accept, drop valid when the result is taken
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (step) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (step) begin
      out_reg <= result;
    end
  end

  // Pack the result fields
  assign m_tdata[4:0]    = out_reg.command;
  assign m_tdata[7:5]    = out_reg.param_count;
  assign m_tdata[23:8]   = out_reg.raw_param[0];
  assign m_tdata[39:24]  = out_reg.raw_param[1];
  assign m_tdata[55:40]  = out_reg.raw_param[2];
  assign m_tdata[71:56]  = out_reg.raw_param[3];
  assign m_tdata[87:72]  = out_reg.first_or_one;
  assign m_tdata[103:88] = out_reg.second_or_one;
  assign m_tuser[0]      = out_reg.handled;
  assign m_tuser[1]      = out_reg.unknown_sequence;

endmodule

// ===== rtl/core/aesp_checker.sv =====
// Port-level checks for the escape sequence parser, bound to the top level.
module aesp_checker (
  input logic         clk,
  input logic         rst,
  input logic         m_tvalid,
  input logic         m_tready,
  input logic [103:0] m_tdata,
  input logic [1:0]   m_tuser
);

  // A stalled result stays valid
  a_hold_valid: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid)
    else $error("result dropped while stalled");

  // A stalled result keeps its payload
  a_hold_data: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> $stable(m_tdata) && $stable(m_tuser))
    else $error("result changed while stalled");

  // An aborted sequence is never reported as consumed
  a_unknown_unhandled: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tuser[1] |-> !m_tuser[0])
    else $error("unknown sequence marked handled");

  // A command only comes with a consumed character
  a_cmd_handled: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tdata[4:0] != 5'd0 |-> m_tuser[0] && m_tdata[7:5] != 3'd0 ||
      m_tvalid && m_tdata[4:0] != 5'd0 && m_tuser[0])
    else $error("command without handled character");

  // No command means empty parameters and defaults of one
  a_no_cmd_params: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tdata[4:0] == 5'd0 |->
      m_tdata[71:5] == '0 && m_tdata[87:72] == 16'd1 && m_tdata[103:88] == 16'd1)
    else $error("parameters present without a command");

endmodule

bind ansi_escape_sequence_parser_unit aesp_checker u_aesp_checker (.*);
